// ===== src/gregorian_date_up_down_counter_unit_defines.svh =====
// assertion macros shared by the date counter checks
`ifndef GREGORIAN_DATE_UP_DOWN_COUNTER_UNIT_DEFINES_SVH
`define GREGORIAN_DATE_UP_DOWN_COUNTER_UNIT_DEFINES_SVH

// same-cycle implication, off while reset is asserted
`define GDUC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("gduc check failed");

// next-cycle implication, off while reset is asserted
`define GDUC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("gduc check failed");

// next-cycle implication that also holds across reset
`define GDUC_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("gduc check failed");

`endif

// ===== src/gduc_pkg.sv =====
// types, constants, month table and microcode program of the date counter
package gduc_pkg;

    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int COUNT_W  = 10;
    localparam int CMD_W    = 2;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 24;
    localparam int REM_W    = 7;
    localparam int PROD_W   = 27;

    localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST   = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_DEC31   = 5'd31;
    localparam logic [REM_W-1:0]   YEAR_IN_CENT_LAST = 7'd99;

    // year / 100 == (year * 5243) >> 19, exact for every 14-bit year below 10000
    localparam logic [PROD_W-1:0]  RECIP_100   = 27'd5243;
    localparam int                 RECIP_SHIFT = 19;
    localparam logic [YEAR_W-1:0]  CENTURY     = 14'd100;

    typedef logic [2:0] pc_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD = 2'd0,
        CMD_ADD  = 2'd1,
        CMD_SUB  = 2'd2,
        CMD_HOLD = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_LD_CLAMP,
        OP_LD_SPLIT,
        OP_LD_DAY,
        OP_STEP,
        OP_EMIT,
        OP_NOP
    } op_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_JUMP,
        COND_DISPATCH,
        COND_STEPS_DONE,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ctrl_t;

    typedef struct packed {
        logic in_accept;
        cmd_t in_cmd;
        logic steps_zero;
        logic out_free;
    } flags_t;

    localparam pc_t PC_IDLE     = 3'd0;
    localparam pc_t PC_LD_CLAMP = 3'd1;
    localparam pc_t PC_LD_SPLIT = 3'd2;
    localparam pc_t PC_LD_DAY   = 3'd3;
    localparam pc_t PC_STEP     = 3'd4;
    localparam pc_t PC_EMIT     = 3'd5;

    // days in a month, february by leap flag
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd2:                     len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
            default:                  len = 5'd31;
        endcase
        return len;
    endfunction

    // control store
    function automatic ctrl_t mc_rom(input pc_t pc);
        ctrl_t w;
        unique case (pc)
            PC_IDLE:     w = '{op: OP_IDLE,     cond: COND_DISPATCH,   target: PC_IDLE};
            PC_LD_CLAMP: w = '{op: OP_LD_CLAMP, cond: COND_NEXT,       target: PC_IDLE};
            PC_LD_SPLIT: w = '{op: OP_LD_SPLIT, cond: COND_NEXT,       target: PC_IDLE};
            PC_LD_DAY:   w = '{op: OP_LD_DAY,   cond: COND_JUMP,       target: PC_EMIT};
            PC_STEP:     w = '{op: OP_STEP,     cond: COND_STEPS_DONE, target: PC_EMIT};
            PC_EMIT:     w = '{op: OP_EMIT,     cond: COND_OUT_FREE,   target: PC_IDLE};
            default:     w = '{op: OP_NOP,      cond: COND_JUMP,       target: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== src/gduc_sequencer.sv =====
// step counter and branch logic that walks the control store
module gduc_sequencer (
    input  logic            aclk,
    input  logic            aresetn,
    input  gduc_pkg::flags_t flags,
    output gduc_pkg::ctrl_t  ctrl
);
    import gduc_pkg::*;

    pc_t pc_reg;
    pc_t pc_next;

    // control word of the current step
    assign ctrl = mc_rom(pc_reg);

    // next step
    always_comb begin
        pc_next = pc_reg;
        unique case (ctrl.cond)
            COND_NEXT:       pc_next = pc_reg + 3'd1;
            COND_JUMP:       pc_next = ctrl.target;
            COND_DISPATCH: begin
                if (flags.in_accept) begin
                    unique case (flags.in_cmd)
                        CMD_LOAD:         pc_next = PC_LD_CLAMP;
                        CMD_ADD, CMD_SUB: pc_next = PC_STEP;
                        CMD_HOLD:         pc_next = PC_EMIT;
                        default:          pc_next = PC_IDLE;
                    endcase
                end
            end
            COND_STEPS_DONE: if (flags.steps_zero) pc_next = ctrl.target;
            COND_OUT_FREE:   if (flags.out_free) pc_next = ctrl.target;
            default:         pc_next = PC_IDLE;
        endcase
    end

    // step register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== src/gduc_datapath.sv =====
// date registers, day stepper, load clamping and output register
module gduc_datapath #(
    parameter int MAX_STEP_COUNT = 1023
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  gduc_pkg::ctrl_t                      ctrl,
    output gduc_pkg::flags_t                     flags,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [gduc_pkg::S_DATA_W-1:0]        s_tdata,
    input  logic [gduc_pkg::CMD_W-1:0]           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [gduc_pkg::M_DATA_W-1:0]        m_tdata
);
    import gduc_pkg::*;

    localparam int SW = $clog2(MAX_STEP_COUNT + 1);
    localparam int CW = (SW > COUNT_W) ? SW : COUNT_W;
    localparam logic [CW-1:0] MAX_EXT = CW'(MAX_STEP_COUNT);

    // input fields
    logic [DAY_W-1:0]   s_day;
    logic [MONTH_W-1:0] s_month;
    logic [YEAR_W-1:0]  s_year;
    logic [COUNT_W-1:0] s_count;
    logic [CW-1:0]      cnt_ext;

    cmd_t               cmd_reg, cmd_next;
    logic [DAY_W-1:0]   day_reg, day_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [REM_W-1:0]   cent_reg, cent_next;
    logic [DAY_W-1:0]   ld_day_reg, ld_day_next;
    logic [MONTH_W-1:0] ld_month_reg, ld_month_next;
    logic [YEAR_W-1:0]  ld_year_reg, ld_year_next;
    logic [SW-1:0]      steps_reg, steps_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic               m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    logic               in_accept;
    logic               out_free;
    logic               leap;
    logic [DAY_W-1:0]   cur_len;
    logic [MONTH_W-1:0] m_clamp;
    logic [YEAR_W-1:0]  y_clamp;
    logic [REM_W-1:0]   cent_split;
    logic [YEAR_W-1:0]  cent_times;

    assign s_day   = s_tdata[DAY_W-1:0];
    assign s_month = s_tdata[DAY_W +: MONTH_W];
    assign s_year  = s_tdata[DAY_W+MONTH_W +: YEAR_W];
    assign s_count = s_tdata[DAY_W+MONTH_W+YEAR_W +: COUNT_W];
    assign cnt_ext = CW'(s_count);

    // handshake status
    assign s_tready  = (ctrl.op == OP_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    assign flags.in_accept  = in_accept;
    assign flags.in_cmd     = cmd_t'(s_tuser);
    assign flags.steps_zero = (steps_reg == '0);
    assign flags.out_free   = out_free;

    // leap flag from year mod 4, year mod 100 and century mod 4
    assign leap = (year_reg[1:0] == 2'b00) && ((rem_reg != '0) || (cent_reg[1:0] == 2'b00));
    assign cur_len = month_len(month_reg, leap);

    // load clamping and century split
    assign m_clamp = (ld_month_reg < MONTH_FIRST) ? MONTH_FIRST :
                     (ld_month_reg > MONTH_LAST)  ? MONTH_LAST  : ld_month_reg;
    assign y_clamp = (ld_year_reg < YEAR_MIN) ? YEAR_MIN :
                     (ld_year_reg > YEAR_MAX) ? YEAR_MAX : ld_year_reg;
    assign cent_split = prod_reg[RECIP_SHIFT +: REM_W];
    assign cent_times = YEAR_W'(cent_split) * CENTURY;

    always_comb begin
        cmd_next      = cmd_reg;
        day_next      = day_reg;
        month_next    = month_reg;
        year_next     = year_reg;
        rem_next      = rem_reg;
        cent_next     = cent_reg;
        ld_day_next   = ld_day_reg;
        ld_month_next = ld_month_reg;
        ld_year_next  = ld_year_reg;
        steps_next    = steps_reg;
        prod_next     = prod_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;

        unique case (ctrl.op)
            // take in one transfer
            OP_IDLE: begin
                if (in_accept) begin
                    cmd_next      = cmd_t'(s_tuser);
                    ld_day_next   = s_day;
                    ld_month_next = s_month;
                    ld_year_next  = s_year;
                    steps_next    = SW'((cnt_ext > MAX_EXT) ? MAX_EXT : cnt_ext);
                end
            end
            // clamp month and year, start the century split
            OP_LD_CLAMP: begin
                month_next = m_clamp;
                year_next  = y_clamp;
                prod_next  = PROD_W'(y_clamp) * RECIP_100;
            end
            OP_LD_SPLIT: begin
                cent_next = cent_split;
                rem_next  = REM_W'(year_reg - cent_times);
            end
            // clamp day to the month length
            OP_LD_DAY: begin
                if (ld_day_reg < DAY_FIRST) begin
                    day_next = DAY_FIRST;
                end else if (ld_day_reg > cur_len) begin
                    day_next = cur_len;
                end else begin
                    day_next = ld_day_reg;
                end
            end
            // one day forward or back
            OP_STEP: begin
                if (steps_reg != '0) begin
                    steps_next = steps_reg - SW'(1);
                    if (cmd_reg == CMD_ADD) begin
                        if (day_reg >= cur_len) begin
                            if (month_reg >= MONTH_LAST) begin
                                if (year_reg >= YEAR_MAX) begin
                                    steps_next = '0;
                                end else begin
                                    year_next  = year_reg + 14'd1;
                                    month_next = MONTH_FIRST;
                                    day_next   = DAY_FIRST;
                                    if (rem_reg == YEAR_IN_CENT_LAST) begin
                                        rem_next  = '0;
                                        cent_next = cent_reg + 7'd1;
                                    end else begin
                                        rem_next = rem_reg + 7'd1;
                                    end
                                end
                            end else begin
                                month_next = month_reg + 4'd1;
                                day_next   = DAY_FIRST;
                            end
                        end else begin
                            day_next = day_reg + 5'd1;
                        end
                    end else begin
                        if (day_reg <= DAY_FIRST) begin
                            if (month_reg <= MONTH_FIRST) begin
                                if (year_reg <= YEAR_MIN) begin
                                    steps_next = '0;
                                end else begin
                                    year_next  = year_reg - 14'd1;
                                    month_next = MONTH_LAST;
                                    day_next   = DAY_DEC31;
                                    if (rem_reg == '0) begin
                                        rem_next  = YEAR_IN_CENT_LAST;
                                        cent_next = cent_reg - 7'd1;
                                    end else begin
                                        rem_next = rem_reg - 7'd1;
                                    end
                                end
                            end else begin
                                month_next = month_reg - 4'd1;
                                day_next   = month_len(month_reg - 4'd1, leap);
                            end
                        end else begin
                            day_next = day_reg - 5'd1;
                        end
                    end
                end
            end
            // hand the date to the output register
            OP_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {leap, year_reg, month_reg, day_reg};
                end
            end
            default: begin
            end
        endcase
    end

    // control and date state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            day_reg     <= DAY_FIRST;
            month_reg   <= MONTH_FIRST;
            year_reg    <= 14'd2000;
            rem_reg     <= '0;
            cent_reg    <= 7'd20;
            steps_reg   <= '0;
            cmd_reg     <= CMD_HOLD;
        end else begin
            m_valid_reg <= m_valid_next;
            day_reg     <= day_next;
            month_reg   <= month_next;
            year_reg    <= year_next;
            rem_reg     <= rem_next;
            cent_reg    <= cent_next;
            steps_reg   <= steps_next;
            cmd_reg     <= cmd_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        ld_day_reg   <= ld_day_next;
        ld_month_reg <= ld_month_next;
        ld_year_reg  <= ld_year_next;
        prod_reg     <= prod_next;
        m_data_reg   <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== src/gregorian_date_up_down_counter_unit.sv =====
// date counter: load a date or step it by days, one date result per transfer
// add/subtract walks the stepper (one day per cycle) and emits the result, load
// clamps month, year and then day before emitting, hold emits the current date
// throughput: one item at a time, the next transfer is taken once the result
// sits in the output register
// reset: synchronous active-low, date returns to 1 january 2000, no result held
module gregorian_date_up_down_counter_unit #(
    parameter int MAX_STEP_COUNT = 1023
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // load_day[4:0], load_month[8:5], load_year[22:9], day_count[32:23], zero pad
    input  logic [gduc_pkg::S_DATA_W-1:0]  s_tdata,
    // cmd[1:0]
    input  logic [gduc_pkg::CMD_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_day[4:0], out_month[8:5], out_year[22:9], leap_year[23]
    output logic [gduc_pkg::M_DATA_W-1:0]  m_tdata
);
    import gduc_pkg::*;

    ctrl_t  ctrl;
    flags_t flags;

    // control store walker
    gduc_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    // date datapath
    gduc_datapath #(
        .MAX_STEP_COUNT (MAX_STEP_COUNT)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .flags    (flags),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== src/gduc_checker.sv =====
// port-level checks of the date counter and their binding
`include "gregorian_date_up_down_counter_unit_defines.svh"

module gduc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    logic stalled;
    logic range_ok;

    // result waiting on the receiver
    assign stalled = m_tvalid && !m_tready;

    // result date in range and leap only on multiples of four
    assign range_ok = (m_tdata[4:0] != 5'd0) && (m_tdata[8:5] != 4'd0) &&
                      (m_tdata[8:5] <= 4'd12) && (m_tdata[22:9] != 14'd0) &&
                      (m_tdata[22:9] <= 14'd9999) &&
                      (!m_tdata[23] || (m_tdata[10:9] == 2'b00));

    // no result right after reset
    `GDUC_ASSERT_NXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid)

    // a stalled result holds
    `GDUC_ASSERT_NXT(a_hold, aclk, aresetn, stalled, m_tvalid && $stable(m_tdata))

    // busy after taking a transfer
    `GDUC_ASSERT_NXT(a_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // every result carries a valid date
    `GDUC_ASSERT_IMP(a_range, aclk, aresetn, m_tvalid, range_ok)

endmodule

bind gregorian_date_up_down_counter_unit gduc_checker u_gduc_checker (.*);
